[design/nmlp_pkg.sv]
// Shared constants, codes and types of the nested map/list stream parser.
package nmlp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH);
	localparam int SUM_W       = $clog2(STACK_DEPTH + 3);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;

	localparam logic [4:0] EV_MESSAGE    = 5'd0;
	localparam logic [4:0] EV_MAP_END    = 5'd1;
	localparam logic [4:0] EV_LIST_END   = 5'd2;
	localparam logic [4:0] EV_LIST_MAP   = 5'd3;
	localparam logic [4:0] EV_LIST_LIST  = 5'd4;
	localparam logic [4:0] EV_NAME_BYTE  = 5'd5;
	localparam logic [4:0] EV_DATA_BYTE  = 5'd6;
	localparam logic [4:0] EV_MAP_MAP    = 5'd7;
	localparam logic [4:0] EV_MAP_LIST   = 5'd8;
	localparam logic [4:0] EV_MAP_INT    = 5'd9;
	localparam logic [4:0] EV_MAP_FLOAT  = 5'd10;
	localparam logic [4:0] EV_MAP_STRING = 5'd11;
	localparam logic [4:0] EV_LIST_INT   = 5'd12;
	localparam logic [4:0] EV_LIST_FLOAT = 5'd13;
	localparam logic [4:0] EV_LIST_STR   = 5'd14;
	localparam logic [4:0] EV_UNEXPECTED = 5'd15;
	localparam logic [4:0] EV_OVERFLOW   = 5'd16;

	typedef struct packed {
		logic [4:0]         ev_code;
		logic [7:0]         char_byte;
		logic signed [63:0] int_value;
		logic               last;
	} res_t;

	// container stack request and status
	typedef struct packed {
		logic push;
		logic pop;
		logic push_list;
	} cs_op_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               top_list;
	} cs_stat_t;

endpackage

[design/nmlp_cstack.sv]
// Container stack: map/list type per nesting level, top cached in flops.
module nmlp_cstack (
	input  logic              clk,
	input  logic              arst_n,
	input  nmlp_pkg::cs_op_t   op,
	output nmlp_pkg::cs_stat_t stat
);
	import nmlp_pkg::*;

	logic               list_mem [STACK_DEPTH];
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_nx;
	logic [DEPTH_W-1:0] rd_addr;
	logic               top_list_q;
	logic               below_rd;

	always_comb begin
		depth_nx = depth_q;
		if (op.push) begin
			depth_nx = depth_q + DEPTH_W'(1);
		end else if (op.pop) begin
			depth_nx = depth_q - DEPTH_W'(1);
		end
		// prefetch the entry under the next top
		rd_addr = (depth_nx == '0) ? '0 : depth_nx - DEPTH_W'(1);
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			list_mem[depth_nx] <= op.push_list;
		end
		below_rd <= list_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			top_list_q <= 1'b0;
		end else begin
			depth_q <= depth_nx;
			if (op.push) begin
				top_list_q <= op.push_list;
			end else if (op.pop) begin
				top_list_q <= below_rd;
			end
		end
	end

	assign stat.depth    = depth_q;
	assign stat.top_list = top_list_q;

endmodule

[design/nmlp_core.sv]
// Parse step: pending item state, integer accumulator and event generation.
module nmlp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         in_byte,
	input  nmlp_pkg::cs_stat_t cs_stat,
	output nmlp_pkg::cs_op_t   cs_op,
	output logic [1:0]         res_cnt,
	output nmlp_pkg::res_t     res0,
	output nmlp_pkg::res_t     res1
);
	import nmlp_pkg::*;

	// pending item above the top container
	localparam logic [2:0] SFX_NONE    = 3'd0;
	localparam logic [2:0] SFX_MAPBEG  = 3'd1;
	localparam logic [2:0] SFX_LISTBEG = 3'd2;
	localparam logic [2:0] SFX_INT     = 3'd3;
	localparam logic [2:0] SFX_FLOAT   = 3'd4;
	localparam logic [2:0] SFX_STRING  = 3'd5;

	logic [2:0]  sfx_q, sfx_nx;
	logic        name_q, name_nx;
	logic [63:0] int_acc_q, acc_nx;
	logic        int_neg_q, neg_nx;
	logic        int_start_q, start_nx;
	logic        clr_int, upd_int;

	logic        delim, digit, sign, float_ch;
	logic        ok1, ok2, ok3;
	logic        rehandle, use_cont;
	logic        p1_v, p2_v;
	logic [4:0]  p1_ev, p2_ev;
	logic [7:0]  p1_ch;
	logic [63:0] p1_iv;
	logic [63:0] int_val;
	logic        push_c, pop_c, push_list_c;
	logic [67:0] acc_ext, acc_prod, acc_lim;
	res_t        r1, r2;

	assign delim = (in_byte == CH_LBRACK) || (in_byte == CH_RBRACK) ||
		(in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
		(in_byte == CH_DOLLAR) || (in_byte == CH_AT) || (in_byte == CH_HASH);
	assign digit    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign sign     = (in_byte == CH_MINUS) || (in_byte == CH_PLUS);
	assign float_ch = digit || sign || (in_byte == CH_DOT) ||
		(in_byte == CH_LOW_E) || (in_byte == CH_UP_E);

	assign ok1 = (SUM_W'(cs_stat.depth) + SUM_W'(1)) < SUM_W'(STACK_DEPTH);
	assign ok2 = (SUM_W'(cs_stat.depth) + SUM_W'(2)) < SUM_W'(STACK_DEPTH);
	assign ok3 = (SUM_W'(cs_stat.depth) + SUM_W'(3)) < SUM_W'(STACK_DEPTH);

	assign int_val = int_neg_q ? (64'd0 - int_acc_q) : int_acc_q;

	// saturating decimal accumulate: acc*10 + digit, clamp to the signed limit
	always_comb begin
		acc_ext  = {4'b0, int_acc_q};
		acc_prod = (acc_ext << 3) + (acc_ext << 1) + {60'b0, in_byte - CH_ZERO};
		acc_lim  = int_neg_q ? {4'b0, 1'b1, 63'b0} : {5'b0, {63{1'b1}}};
		acc_nx   = int_acc_q;
		neg_nx   = int_neg_q;
		start_nx = int_start_q;
		if (sign) begin
			if (!int_start_q) begin
				neg_nx   = (in_byte == CH_MINUS);
				start_nx = 1'b1;
			end
		end else begin
			start_nx = 1'b1;
			acc_nx   = (acc_prod > acc_lim) ? acc_lim[63:0] : acc_prod[63:0];
		end
	end

	always_comb begin
		p1_v        = 1'b0;
		p1_ev       = EV_MESSAGE;
		p1_ch       = 8'd0;
		p1_iv       = 64'd0;
		p2_v        = 1'b0;
		p2_ev       = EV_MESSAGE;
		rehandle    = 1'b0;
		sfx_nx      = sfx_q;
		name_nx     = name_q;
		clr_int     = 1'b0;
		upd_int     = 1'b0;
		push_c      = 1'b0;
		pop_c       = 1'b0;
		push_list_c = 1'b0;

		// first pass: pending item on top
		if (name_q) begin
			if (in_byte == CH_EQ) begin
				name_nx = 1'b0;
			end else if (delim) begin
				p1_v  = 1'b1;
				p1_ev = EV_UNEXPECTED;
			end else begin
				p1_v  = 1'b1;
				p1_ev = EV_NAME_BYTE;
				p1_ch = in_byte;
			end
		end else begin
			unique case (sfx_q)
				SFX_NONE: begin
				end
				SFX_MAPBEG: begin
					p1_v     = 1'b1;
					p1_ev    = EV_MAP_MAP;
					sfx_nx   = SFX_NONE;
					rehandle = 1'b1;
				end
				SFX_LISTBEG: begin
					p1_v     = 1'b1;
					p1_ev    = EV_MAP_LIST;
					sfx_nx   = SFX_NONE;
					rehandle = 1'b1;
				end
				SFX_INT: begin
					if (delim) begin
						sfx_nx   = SFX_NONE;
						clr_int  = 1'b1;
						rehandle = 1'b1;
						p1_v     = (cs_stat.depth != '0);
						p1_ev    = cs_stat.top_list ? EV_LIST_INT : EV_MAP_INT;
						p1_iv    = int_val;
					end else if (digit || sign) begin
						upd_int = 1'b1;
						p1_v    = 1'b1;
						p1_ev   = EV_DATA_BYTE;
						p1_ch   = in_byte;
					end else begin
						p1_v  = 1'b1;
						p1_ev = EV_UNEXPECTED;
					end
				end
				SFX_FLOAT: begin
					if (delim) begin
						sfx_nx   = SFX_NONE;
						rehandle = 1'b1;
						p1_v     = (cs_stat.depth != '0);
						p1_ev    = cs_stat.top_list ? EV_LIST_FLOAT : EV_MAP_FLOAT;
					end else if (float_ch) begin
						p1_v  = 1'b1;
						p1_ev = EV_DATA_BYTE;
						p1_ch = in_byte;
					end else begin
						p1_v  = 1'b1;
						p1_ev = EV_UNEXPECTED;
					end
				end
				SFX_STRING: begin
					if (delim) begin
						sfx_nx   = SFX_NONE;
						rehandle = 1'b1;
						p1_v     = (cs_stat.depth != '0);
						p1_ev    = cs_stat.top_list ? EV_LIST_STR : EV_MAP_STRING;
					end else if (in_byte == CH_EQ) begin
						p1_v  = 1'b1;
						p1_ev = EV_UNEXPECTED;
					end else begin
						p1_v  = 1'b1;
						p1_ev = EV_DATA_BYTE;
						p1_ch = in_byte;
					end
				end
				default: begin
					p1_v  = 1'b1;
					p1_ev = EV_UNEXPECTED;
				end
			endcase
		end

		// second pass: the top container handles the byte
		use_cont = ((sfx_q == SFX_NONE) && !name_q) || rehandle;
		if (use_cont) begin
			p2_v = 1'b1;
			if (cs_stat.depth == '0) begin
				if (in_byte == CH_LBRACK && ok1) begin
					push_c = 1'b1;
					p2_ev  = EV_MESSAGE;
				end else if (in_byte == CH_LBRACK) begin
					p2_ev = EV_OVERFLOW;
				end else begin
					p2_ev = EV_UNEXPECTED;
				end
			end else if (!cs_stat.top_list) begin
				case (in_byte)
					CH_RBRACK: begin
						p2_ev = EV_MAP_END;
						pop_c = 1'b1;
					end
					CH_LBRACK, CH_LPAREN: begin
						if (ok3) begin
							p2_v        = 1'b0;
							push_c      = 1'b1;
							push_list_c = (in_byte == CH_LPAREN);
							sfx_nx      = (in_byte == CH_LPAREN) ? SFX_LISTBEG : SFX_MAPBEG;
							name_nx     = 1'b1;
						end else begin
							p2_ev = EV_OVERFLOW;
						end
					end
					CH_DOLLAR, CH_AT, CH_HASH: begin
						clr_int = clr_int || (in_byte == CH_AT);
						if (ok2) begin
							p2_v    = 1'b0;
							sfx_nx  = (in_byte == CH_DOLLAR) ? SFX_STRING :
								(in_byte == CH_AT) ? SFX_INT : SFX_FLOAT;
							name_nx = 1'b1;
						end else begin
							p2_ev = EV_OVERFLOW;
						end
					end
					default: p2_ev = EV_UNEXPECTED;
				endcase
			end else begin
				case (in_byte)
					CH_RPAREN: begin
						p2_ev = EV_LIST_END;
						pop_c = 1'b1;
					end
					CH_LBRACK, CH_LPAREN: begin
						if (ok1) begin
							push_c      = 1'b1;
							push_list_c = (in_byte == CH_LPAREN);
							p2_ev       = (in_byte == CH_LPAREN) ? EV_LIST_LIST : EV_LIST_MAP;
						end else begin
							p2_ev = EV_OVERFLOW;
						end
					end
					CH_DOLLAR, CH_AT, CH_HASH: begin
						clr_int = clr_int || (in_byte == CH_AT);
						if (ok1) begin
							p2_v   = 1'b0;
							sfx_nx = (in_byte == CH_DOLLAR) ? SFX_STRING :
								(in_byte == CH_AT) ? SFX_INT : SFX_FLOAT;
						end else begin
							p2_ev = EV_OVERFLOW;
						end
					end
					default: p2_ev = EV_UNEXPECTED;
				endcase
			end
		end
	end

	assign cs_op.push      = go && push_c;
	assign cs_op.pop       = go && pop_c;
	assign cs_op.push_list = push_list_c;

	always_comb begin
		r1.ev_code   = p1_ev;
		r1.char_byte = p1_ch;
		r1.int_value = $signed(p1_iv);
		r1.last      = !p2_v;
		r2.ev_code   = p2_ev;
		r2.char_byte = 8'd0;
		r2.int_value = 64'sd0;
		r2.last      = 1'b1;
		res_cnt      = {1'b0, p1_v} + {1'b0, p2_v};
		res0         = p1_v ? r1 : r2;
		res1         = r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfx_q       <= SFX_NONE;
			name_q      <= 1'b0;
			int_acc_q   <= 64'd0;
			int_neg_q   <= 1'b0;
			int_start_q <= 1'b0;
		end else if (go) begin
			sfx_q  <= sfx_nx;
			name_q <= name_nx;
			if (clr_int) begin
				int_acc_q   <= 64'd0;
				int_neg_q   <= 1'b0;
				int_start_q <= 1'b0;
			end else if (upd_int) begin
				int_acc_q   <= acc_nx;
				int_neg_q   <= neg_nx;
				int_start_q <= start_nx;
			end
		end
	end

endmodule

[design/nmlp_res_fifo.sv]
// Result queue: takes up to two results per step, hands out one per cycle while rd_ready is high.
module nmlp_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     wr_cnt,
	input  nmlp_pkg::res_t wr0,
	input  nmlp_pkg::res_t wr1,
	output logic           room,
	output logic           rd_valid,
	input  logic           rd_ready,
	output nmlp_pkg::res_t rd_data
);
	import nmlp_pkg::*;

	res_t                  buf_mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = buf_mem[rp_q];
	assign pop      = rd_valid && rd_ready;
	// room for a full two-result step
	assign room     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			buf_mem[wp_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			buf_mem[wp_q + FIFO_PTR_W'(1)] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_PTR_W'(wr_cnt);
			rp_q  <= rp_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(wr_cnt) - FIFO_CNT_W'(pop);
		end
	end

endmodule

[design/nested_map_list_stream_parser_top.sv]
// Top level of the nested map/list stream parser.
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+------------------------------------------
//  input   | byte_valid | byte_ready | in_byte
//  result  | res_valid  | res_ready  | event_res, char_byte, int_value, last
//
// A byte is registered, then parsed into zero, one or two result
// items that enter a four-item result queue. With the result side always
// ready, the result queue's one read per cycle sets the byte rate when bytes
// give two results. A result passes the byte register, then the queue.
// Reset leaves the parser at stream level with an empty queue, ready at once.
// A stalled result side holds the queue; bytes keep entering until it has no
// room for a two-result step.
module nested_map_list_stream_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         in_byte,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [4:0]         event_res,
	output logic [7:0]         char_byte,
	output logic signed [63:0] int_value,
	output logic               last
);
	import nmlp_pkg::*;

	logic       byte_v_s1;
	logic [7:0] in_byte_s1;
	logic       room, adv;
	cs_op_t     cs_op;
	cs_stat_t   cs_stat;
	logic [1:0] res_cnt;
	res_t       res0, res1, rd_data;

	assign adv        = byte_v_s1 && room;
	assign byte_ready = !byte_v_s1 || adv;

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			in_byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			byte_v_s1 <= 1'b1;
		end else if (adv) begin
			byte_v_s1 <= 1'b0;
		end
	end

	nmlp_cstack u_cstack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cs_op),
		.stat   (cs_stat)
	);

	nmlp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (adv),
		.in_byte (in_byte_s1),
		.cs_stat (cs_stat),
		.cs_op   (cs_op),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	nmlp_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (adv ? res_cnt : 2'd0),
		.wr0      (res0),
		.wr1      (res1),
		.room     (room),
		.rd_valid (res_valid),
		.rd_ready (res_ready),
		.rd_data  (rd_data)
	);

	assign event_res = rd_data.ev_code;
	assign char_byte = rd_data.char_byte;
	assign int_value = rd_data.int_value;
	assign last      = rd_data.last;

endmodule

[sim/nmlp_event_checker.sv]
// Event checker for the nested map/list stream parser: byte-level prediction and result compare.
module nmlp_event_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_ready,
	input  logic [7:0]         in_byte,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [4:0]         event_res,
	input  logic [7:0]         char_byte,
	input  logic signed [63:0] int_value,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 nest_depth,
	output int                 events_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import nmlp_pkg::*;

	typedef enum logic [3:0] {
		PS_STREAM,
		PS_MAP,
		PS_LIST,
		PS_MAP_BEGIN,
		PS_LIST_BEGIN,
		PS_INT,
		PS_FLOAT,
		PS_STRING,
		PS_NAME
	} parse_state_t;

	localparam int MAX_EVENTS_PER_BYTE = 2;
	localparam int REPORT_LIMIT        = 10;

	parse_state_t nest_stack [STACK_DEPTH];
	int unsigned  top_idx;
	logic [63:0]  int_mag;
	logic         int_neg;
	logic         int_seen;
	int           step_events;
	res_t         expected_events [$];

	function automatic bit is_delim(logic [7:0] b);
		return b == CH_LBRACK || b == CH_RBRACK || b == CH_LPAREN || b == CH_RPAREN ||
			b == CH_DOLLAR || b == CH_AT || b == CH_HASH;
	endfunction

	function automatic void add_event(logic [4:0] code, logic [7:0] ch, logic [63:0] val);
		res_t r;
		if (step_events < MAX_EVENTS_PER_BYTE) begin
			r.ev_code   = code;
			r.char_byte = ch;
			r.int_value = val;
			r.last      = 1'b0;
			expected_events.push_back(r);
			step_events++;
		end
	endfunction

	// all or nothing: an overflowing push leaves the stack untouched
	function automatic bit push_states(int n, parse_state_t a, parse_state_t b, parse_state_t c);
		parse_state_t s [3];
		if (top_idx + n >= STACK_DEPTH) return 1'b0;
		s[0] = a;
		s[1] = b;
		s[2] = c;
		for (int i = 0; i < n; i++) begin
			top_idx++;
			nest_stack[top_idx] = s[i];
		end
		return 1'b1;
	endfunction

	function automatic void pop_state();
		if (top_idx > 0) top_idx--;
	endfunction

	function automatic void clear_int();
		int_mag  = 64'd0;
		int_neg  = 1'b0;
		int_seen = 1'b0;
	endfunction

	function automatic void take_int_char(logic [7:0] b);
		logic [63:0] limit;
		logic [63:0] d;
		if (b == CH_MINUS || b == CH_PLUS) begin
			// only a leading sign counts
			if (!int_seen) begin
				int_neg  = (b == CH_MINUS);
				int_seen = 1'b1;
			end
			return;
		end
		limit    = int_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		d        = b - CH_ZERO;
		int_seen = 1'b1;
		if (int_mag > (limit - d) / 10) int_mag = limit;
		else int_mag = int_mag * 10 + d;
	endfunction

	function automatic void end_scalar(logic [4:0] map_code, logic [4:0] list_code,
		logic [63:0] val);
		parse_state_t owner;
		pop_state();
		owner = nest_stack[top_idx];
		if (owner == PS_MAP) add_event(map_code, 8'd0, val);
		else if (owner == PS_LIST) add_event(list_code, 8'd0, val);
	endfunction

	// one pass over the byte; returns 1 when the enclosing state must see it again
	function automatic bit parse_one(logic [7:0] b);
		bit          ok;
		logic [63:0] v;
		ok = 1'b1;
		case (nest_stack[top_idx % STACK_DEPTH])
		PS_STREAM: begin
			if (b == CH_LBRACK) begin
				if (push_states(1, PS_MAP, PS_STREAM, PS_STREAM))
					add_event(EV_MESSAGE, 8'd0, 64'd0);
				else
					add_event(EV_OVERFLOW, 8'd0, 64'd0);
			end else begin
				add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			end
			return 1'b0;
		end
		PS_MAP: begin
			if (b == CH_RBRACK) begin
				add_event(EV_MAP_END, 8'd0, 64'd0);
				pop_state();
				return 1'b0;
			end
			if (b == CH_LBRACK) ok = push_states(3, PS_MAP, PS_MAP_BEGIN, PS_NAME);
			else if (b == CH_LPAREN) ok = push_states(3, PS_LIST, PS_LIST_BEGIN, PS_NAME);
			else if (b == CH_DOLLAR) ok = push_states(2, PS_STRING, PS_NAME, PS_STREAM);
			else if (b == CH_AT) begin
				ok = push_states(2, PS_INT, PS_NAME, PS_STREAM);
				clear_int();
			end else if (b == CH_HASH) ok = push_states(2, PS_FLOAT, PS_NAME, PS_STREAM);
			else begin
				add_event(EV_UNEXPECTED, 8'd0, 64'd0);
				return 1'b0;
			end
			if (!ok) add_event(EV_OVERFLOW, 8'd0, 64'd0);
			return 1'b0;
		end
		PS_LIST: begin
			if (b == CH_RPAREN) begin
				add_event(EV_LIST_END, 8'd0, 64'd0);
				pop_state();
				return 1'b0;
			end
			if (b == CH_LBRACK) begin
				if (push_states(1, PS_MAP, PS_STREAM, PS_STREAM))
					add_event(EV_LIST_MAP, 8'd0, 64'd0);
				else
					ok = 1'b0;
			end else if (b == CH_LPAREN) begin
				if (push_states(1, PS_LIST, PS_STREAM, PS_STREAM))
					add_event(EV_LIST_LIST, 8'd0, 64'd0);
				else
					ok = 1'b0;
			end else if (b == CH_DOLLAR) ok = push_states(1, PS_STRING, PS_STREAM, PS_STREAM);
			else if (b == CH_AT) begin
				ok = push_states(1, PS_INT, PS_STREAM, PS_STREAM);
				clear_int();
			end else if (b == CH_HASH) ok = push_states(1, PS_FLOAT, PS_STREAM, PS_STREAM);
			else begin
				add_event(EV_UNEXPECTED, 8'd0, 64'd0);
				return 1'b0;
			end
			if (!ok) add_event(EV_OVERFLOW, 8'd0, 64'd0);
			return 1'b0;
		end
		PS_MAP_BEGIN: begin
			add_event(EV_MAP_MAP, 8'd0, 64'd0);
			pop_state();
			return 1'b1;
		end
		PS_LIST_BEGIN: begin
			add_event(EV_MAP_LIST, 8'd0, 64'd0);
			pop_state();
			return 1'b1;
		end
		PS_INT: begin
			if (is_delim(b)) begin
				v = int_neg ? (64'd0 - int_mag) : int_mag;
				end_scalar(EV_MAP_INT, EV_LIST_INT, v);
				clear_int();
				return 1'b1;
			end
			if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_PLUS) begin
				take_int_char(b);
				add_event(EV_DATA_BYTE, b, 64'd0);
			end else begin
				add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			end
			return 1'b0;
		end
		PS_FLOAT: begin
			if (is_delim(b)) begin
				end_scalar(EV_MAP_FLOAT, EV_LIST_FLOAT, 64'd0);
				return 1'b1;
			end
			if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_MINUS ||
				b == CH_PLUS || b == CH_LOW_E || b == CH_UP_E)
				add_event(EV_DATA_BYTE, b, 64'd0);
			else
				add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			return 1'b0;
		end
		PS_STRING: begin
			if (is_delim(b)) begin
				end_scalar(EV_MAP_STRING, EV_LIST_STR, 64'd0);
				return 1'b1;
			end
			if (b == CH_EQ) add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			else add_event(EV_DATA_BYTE, b, 64'd0);
			return 1'b0;
		end
		PS_NAME: begin
			if (b == CH_EQ) pop_state();
			else if (is_delim(b)) add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			else add_event(EV_NAME_BYTE, b, 64'd0);
			return 1'b0;
		end
		default: begin
			add_event(EV_UNEXPECTED, 8'd0, 64'd0);
			return 1'b0;
		end
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		res_t r;
		step_events = 0;
		if (parse_one(b)) void'(parse_one(b));
		if (step_events > 0) begin
			r      = expected_events.pop_back();
			r.last = 1'b1;
			expected_events.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) nest_stack[i] = PS_STREAM;
			top_idx = 0;
			clear_int();
			expected_events.delete();
			fail_count     = 0;
			events_checked = 0;
		end else begin
			// compare before predicting: no byte can produce an event in its own cycle
			if (res_valid && res_ready) begin
				got = {event_res, char_byte, int_value, last};
				events_checked++;
				if (expected_events.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: event %0d ch %02h val %0d last %0b with none pending",
							$realtime, got.ev_code, got.char_byte, got.int_value, got.last);
				end else begin
					want = expected_events.pop_front();
					if (got.ev_code !== want.ev_code || got.char_byte !== want.char_byte ||
						got.int_value !== want.int_value || got.last !== want.last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: expected ev %0d ch %02h val %0d last %0b, got ev %0d ch %02h val %0d last %0b",
								$realtime, want.ev_code, want.char_byte, want.int_value,
								want.last, got.ev_code, got.char_byte, got.int_value, got.last);
					end
				end
			end
			if (byte_valid && byte_ready) predict_byte(in_byte);
		end
		pending    = expected_events.size();
		nest_depth = top_idx;
	end

endmodule

[sim/nested_map_list_stream_parser_top_test.sv]
// Stimulus, flow control and verdict for the nested map/list stream parser.
module nested_map_list_stream_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import nmlp_pkg::*;

	localparam int ITEM_TARGET  = 1650;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 37;
	localparam int STALL_CYCLES = 120;
	localparam int STALL_AT     = 400;
	localparam int CALM_FROM    = 800;
	localparam int CALM_TO      = 1000;
	localparam int DRAIN_AT     = 1200;
	localparam int TAIL_CYCLES  = 8;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	logic [7:0]         in_byte    = 8'd0;
	logic               res_valid;
	logic               res_ready  = 1'b0;
	logic [4:0]         event_res;
	logic [7:0]         char_byte;
	logic signed [63:0] int_value;
	logic               last;

	int fail_count;
	int pending;
	int nest_depth;
	int events_checked;

	bit  calm          = 1'b0;
	int  stall_reqs    = 0;
	int  stalls_served = 0;
	int  hold_left     = 0;
	int  cycle_count   = 0;
	int  bytes_sent    = 0;

	logic [7:0] seq [$];

	nested_map_list_stream_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.event_res (event_res),
		.char_byte (char_byte),
		.int_value (int_value),
		.last      (last)
	);

	nmlp_event_checker event_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.in_byte       (in_byte),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.event_res     (event_res),
		.char_byte     (char_byte),
		.int_value     (int_value),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending),
		.nest_depth    (nest_depth),
		.events_checked(events_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side: random back-pressure, always ready in the calm window, plus one long hold on request
	always @(negedge clk) begin
		if (stall_reqs != stalls_served) begin
			stalls_served <= stall_reqs;
			hold_left     <= STALL_CYCLES;
			res_ready     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (calm) begin
			res_ready <= 1'b1;
		end else begin
			res_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic bit is_delim(logic [7:0] b);
		return b == CH_LBRACK || b == CH_RBRACK || b == CH_LPAREN || b == CH_RPAREN ||
			b == CH_DOLLAR || b == CH_AT || b == CH_HASH;
	endfunction

	// any byte a name or string may carry
	function automatic logic [7:0] free_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (is_delim(b) || b == CH_EQ);
		return b;
	endfunction

	function automatic void add_int_text();
		string edges [3] = '{"9223372036854775807", "-9223372036854775808",
			"-9223372036854775809"};
		int    r;
		int    n;
		string pick;
		r = $urandom_range(99);
		if (r < 6) begin
			pick = edges[$urandom_range(2)];
			for (int i = 0; i < pick.len(); i++) seq.push_back(pick[i]);
			return;
		end
		n = (r < 20) ? $urandom_range(18, 22) : $urandom_range(0, 4);
		case ($urandom_range(2))
		0: seq.push_back(CH_MINUS);
		1: seq.push_back(CH_PLUS);
		default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			seq.push_back(CH_ZERO + 8'($urandom_range(9)));
			// stray sign: passed through but ignored for the value
			if (r > 94) seq.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
		end
	endfunction

	function automatic void add_scalar_text(logic [7:0] tag);
		string float_set = "0123456789.-+eE";
		int    n;
		n = $urandom_range(4);
		if (tag == CH_AT) add_int_text();
		else if (tag == CH_HASH)
			for (int i = 0; i < n; i++) seq.push_back(float_set[$urandom_range(14)]);
		else
			for (int i = 0; i < n; i++) seq.push_back(free_byte());
	endfunction

	function automatic void add_item(bit in_list, int level);
		logic [7:0] tag;
		int         kind;
		int         n;
		kind = (level < 3) ? $urandom_range(4) : $urandom_range(2);
		tag  = (kind == 0) ? CH_DOLLAR : (kind == 1) ? CH_AT : (kind == 2) ? CH_HASH :
			(kind == 3) ? CH_LBRACK : CH_LPAREN;
		seq.push_back(tag);
		if (!in_list) begin
			n = $urandom_range(3);
			for (int i = 0; i < n; i++) seq.push_back(free_byte());
			seq.push_back(CH_EQ);
		end
		if (kind < 3) begin
			add_scalar_text(tag);
		end else begin
			n = $urandom_range(3);
			for (int i = 0; i < n; i++) add_item(kind == 4, level + 1);
			seq.push_back((kind == 3) ? CH_RBRACK : CH_RPAREN);
		end
	endfunction

	function automatic void add_message();
		int n;
		n = $urandom_range(4);
		seq.push_back(CH_LBRACK);
		for (int i = 0; i < n; i++) add_item(1'b0, 0);
		seq.push_back(CH_RBRACK);
	endfunction

	// enter at a falling edge, leave at the falling edge after acceptance
	task automatic send_byte(logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_seq();
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	initial begin : stimulus
		int  round;
		int  pick;
		int  keep;
		int  n;
		bit  stall_done;
		bit  drain_done;
		round      = 0;
		stall_done = 1'b0;
		drain_done = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every event code but overflow, signs in int text, empty int, empty names, nested end
		seq = '{8'h00, CH_LBRACK, CH_DOLLAR, "s", CH_EQ, 8'hFF, CH_AT, CH_EQ, CH_PLUS,
			CH_MINUS, "5", CH_HASH, CH_EQ, CH_LPAREN, CH_EQ, CH_AT, CH_HASH, CH_DOLLAR,
			CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN, CH_RPAREN, CH_LBRACK, CH_EQ,
			CH_RBRACK, CH_RBRACK};
		send_seq();

		while (bytes_sent < ITEM_TARGET) begin
			if (!stall_done && bytes_sent >= STALL_AT) begin
				stall_reqs++;
				stall_done = 1'b1;
			end
			calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
			if (!drain_done && bytes_sent >= DRAIN_AT) begin
				byte_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
				drain_done = 1'b1;
			end
			seq.delete();
			pick = (round < 2) ? 99 : $urandom_range(99);
			if (pick < 76) begin
				add_message();
			end else if (pick < 86) begin
				// broken message: cut short anywhere
				add_message();
				keep = $urandom_range(1, seq.size() - 1);
				while (seq.size() > keep) void'(seq.pop_back());
			end else if (pick < 96) begin
				n = $urandom_range(1, 6);
				repeat (n) seq.push_back(8'($urandom_range(255)));
			end else begin
				// nest past the stack limit
				seq.push_back(CH_LBRACK);
				if (round == 0 || (round > 1 && $urandom_range(1))) begin
					seq.push_back(CH_LPAREN);
					seq.push_back(CH_EQ);
					repeat (32) seq.push_back(CH_LPAREN);
				end else begin
					repeat (31) begin
						seq.push_back(CH_LBRACK);
						seq.push_back(CH_EQ);
					end
				end
			end
			send_seq();
			// unwind to stream level: each triple pops at least one level
			while (nest_depth != 0) begin
				send_byte(CH_EQ);
				send_byte(CH_RBRACK);
				send_byte(CH_RPAREN);
			end
			round++;
		end

		byte_valid <= 1'b0;
		calm = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Run covered %0d stream bytes: directed events, nested messages, noise,",
			bytes_sent);
		$display("broken messages, int saturation and stack overflow; %0d events checked.",
			events_checked);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
